### src/dlb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlb_pkg
// Shared widths, constants and the command/status types that join the
// controller and the datapath of the discrete logarithm engine.
// ----------------------------------------------------------------------------
package dlb_pkg;

    localparam int unsigned DATA_W  = 32;   // operand and key width
    localparam int unsigned EXP_W   = 17;   // baby-step exponent, holds m
    localparam int unsigned SQRT_W  = 16;   // integer square root of a 32-bit value
    localparam int unsigned SQBIT_W = 4;    // bit index into the root
    localparam int unsigned E_W     = 49;   // (p - 2) * m
    localparam int unsigned EBIT_W  = 6;    // bit index into the exponent
    localparam int unsigned QM_W    = 34;   // q * m + r

    // Golden-ratio hash multiplier, split in 32-bit halves
    localparam logic [DATA_W-1:0] HASH_C_HI = 32'h9E37_79B9;
    localparam logic [DATA_W-1:0] HASH_C_LO = 32'h7F4A_7C15;

    // Which operands the modular multiplier takes and where the product goes
    typedef enum logic [1:0] {
        MUL_BABY  = 2'd0,   // running power * base
        MUL_SQ    = 2'd1,   // exponentiation square
        MUL_POWB  = 2'd2,   // exponentiation multiply by base
        MUL_GIANT = 2'd3    // giant value * factor
    } t_mul_op;

    typedef struct packed {
        logic    load;        // latch the input item
        logic    prep;        // start root and base reduction
        logic    clr_step;    // clear one table entry
        logic    giant;       // key is the giant value
        logic    hash_start;
        logic    rd;          // read the table at the slot index
        logic    probe_next;  // move to the next slot
        logic    tab_wr;      // store running power with its exponent
        logic    mul_start;
        t_mul_op mul_op;
        logic    r_next;
        logic    pow_init;
        logic    bit_next;
        logic    g_init;
        logic    q_next;
        logic    res_hit;
        logic    res_miss;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic mod_small;
        logic clr_last;
        logic hash_done;
        logic ent_valid;
        logic key_hit;
        logic probe_last;
        logic mul_done;
        logic r_last;
        logic bit_set;
        logic bit_last;
        logic q_last;
        logic x_ok;
    } t_dp_sts;

endpackage

### src/dlb_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlb_in_if
// Input channel: valid/ready with base, target and modulus.
// ----------------------------------------------------------------------------
interface dlb_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] base;
    logic [31:0] target;
    logic [31:0] modulus;

    modport source (output valid, output base, output target, output modulus,
                    input ready);
    modport sink   (input valid, input base, input target, input modulus,
                    output ready);
endinterface

### src/dlb_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlb_out_if
// Output channel: valid/ready with the found flag and the logarithm.
// ----------------------------------------------------------------------------
interface dlb_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] log_value;

    modport source (output valid, output found, output log_value, input ready);
    modport sink   (input valid, input found, input log_value, output ready);
endinterface

### src/dlb_rem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlb_rem
// Restoring remainder unit, one numerator bit per cycle.
// ----------------------------------------------------------------------------
module dlb_rem import dlb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_num,
    input  logic [DATA_W-1:0] i_den,
    output logic              o_done,
    output logic [DATA_W-1:0] o_rem
);
    localparam int unsigned CNT_W = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

    logic              r_busy, r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_num, r_den, r_acc;
    logic [DATA_W:0]   w_try, w_sub;

    // shift in the next numerator bit, subtract when it fits
    always_comb begin
        w_try = {r_acc, r_num[DATA_W-1]};
        w_sub = (w_try >= {1'b0, r_den}) ? (w_try - {1'b0, r_den}) : w_try;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_LAST);
            if (i_start)
                r_busy <= 1'b1;
            else if (r_busy && (r_cnt == CNT_LAST))
                r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_acc <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DATA_W-2:0], 1'b0};
            r_acc <= w_sub[DATA_W-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_acc;
endmodule

### src/dlb_modmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlb_modmul
// Interleaved modular multiplier: x * y mod p, one bit of y per cycle.
// x must be below p; y may be any value.
// ----------------------------------------------------------------------------
module dlb_modmul import dlb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_x,
    input  logic [DATA_W-1:0] i_y,
    input  logic [DATA_W-1:0] i_p,
    output logic              o_done,
    output logic [DATA_W-1:0] o_prod
);
    localparam int unsigned CNT_W = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

    logic              r_busy, r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_x, r_y, r_p, r_acc;
    logic [DATA_W:0]   w_dbl_raw, w_dbl, w_sum_raw, w_sum;

    // acc = 2*acc mod p, then add x when the current bit of y is set
    always_comb begin
        w_dbl_raw = {r_acc, 1'b0};
        w_dbl     = (w_dbl_raw >= {1'b0, r_p}) ? (w_dbl_raw - {1'b0, r_p}) : w_dbl_raw;
        w_sum_raw = w_dbl + (r_y[DATA_W-1] ? {1'b0, r_x} : '0);
        w_sum     = (w_sum_raw >= {1'b0, r_p}) ? (w_sum_raw - {1'b0, r_p}) : w_sum_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_LAST);
            if (i_start)
                r_busy <= 1'b1;
            else if (r_busy && (r_cnt == CNT_LAST))
                r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_p   <= i_p;
            r_acc <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_y   <= {r_y[DATA_W-2:0], 1'b0};
            r_acc <= w_sum[DATA_W-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

### src/dlb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlb_datapath
// Operand registers, integer square root, base reduction, slot hash,
// hash table memory, modular multiplier and result registers.
// ----------------------------------------------------------------------------
module dlb_datapath import dlb_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = 131072
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [DATA_W-1:0] i_base,
    input  logic [DATA_W-1:0] i_target,
    input  logic [DATA_W-1:0] i_modulus,
    output t_dp_sts           o_sts,
    output logic              o_found,
    output logic [DATA_W-1:0] o_log_value
);
    localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
    localparam int unsigned ENT_W  = 1 + DATA_W + EXP_W;
    localparam bit          IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
    localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [DATA_W-1:0] DEPTH_D  = DATA_W'(TABLE_DEPTH);
    // floor(2^32 / depth): quotient estimate is at most one short
    localparam logic [DATA_W-1:0] HASH_RECIP = DATA_W'((64'd1 << DATA_W) / TABLE_DEPTH);

    // item operands
    logic [DATA_W-1:0] r_base, r_target, r_p;

    // loop state
    logic [DATA_W-1:0] r_rp, r_acc, r_g;
    logic [EXP_W-1:0]  r_r, r_q, r_m;
    logic [E_W-1:0]    r_e;
    logic [EBIT_W-1:0] r_bit;
    logic [QM_W-1:0]   r_qm;
    t_mul_op           r_mul_op;

    // square root
    logic               r_sq_busy, r_sq_fin;
    logic [SQBIT_W-1:0] r_sq_bit;
    logic [SQRT_W-1:0]  r_sq_res;
    logic [SQRT_W-1:0]  w_trial;
    logic [DATA_W-1:0]  w_trial_sq;
    logic [SQRT_W-1:0]  w_sq_next;
    logic [E_W-1:0]     w_e;

    // hash
    logic                r_hs1, r_hs2, r_hs3, r_hdone;
    logic [2*DATA_W-1:0] r_hl;
    logic [DATA_W-1:0]   r_hh;
    logic [DATA_W-1:0]   w_h, w_key;
    logic                w_hash_fin;
    logic [IDX_W-1:0]    w_hash_idx;
    logic [2*DATA_W-1:0] w_hq_full;
    logic [DATA_W-1:0]   r_hq, r_hr, w_hr_fix;

    // table
    logic [ENT_W-1:0] mem [TABLE_DEPTH];
    logic [ENT_W-1:0] r_rd;
    logic [IDX_W-1:0] r_idx, r_probe, r_clr_idx;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [ENT_W-1:0] w_wdata;
    logic [QM_W-1:0]  w_x;

    // base reduction and multiplier
    logic              brem_done;
    logic [DATA_W-1:0] w_bred;
    logic              mm_done;
    logic [DATA_W-1:0] mm_prod, w_mx, w_my;

    // results
    logic              r_res_found, r_out_found;
    logic [DATA_W-1:0] r_res_val, r_out_val;

    // ---- operand latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base   <= i_base;
            r_target <= i_target;
            r_p      <= i_modulus;
        end
    end

    // ---- base mod p, once per item
    dlb_rem u_brem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.prep),
        .i_num   (r_base),
        .i_den   (r_p),
        .o_done  (brem_done),
        .o_rem   (w_bred)
    );

    // ---- integer square root, one result bit per cycle; m and (p-2)*m follow
    always_comb begin
        w_trial    = r_sq_res | (SQRT_W'(1) << r_sq_bit);
        w_trial_sq = {{(DATA_W-SQRT_W){1'b0}}, w_trial} * {{(DATA_W-SQRT_W){1'b0}}, w_trial};
        w_sq_next  = (w_trial_sq <= r_p) ? w_trial : r_sq_res;
        w_e        = {{(E_W-DATA_W){1'b0}}, r_p - DATA_W'(2)} * {{(E_W-EXP_W){1'b0}}, r_m};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_busy <= 1'b0;
            r_sq_fin  <= 1'b0;
        end else begin
            r_sq_fin <= r_sq_busy && (r_sq_bit == '0);
            if (i_cmd.prep)
                r_sq_busy <= 1'b1;
            else if (r_sq_busy && (r_sq_bit == '0))
                r_sq_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_sq_res <= '0;
            r_sq_bit <= SQBIT_W'(SQRT_W - 1);
        end else if (r_sq_busy) begin
            r_sq_res <= w_sq_next;
            r_sq_bit <= r_sq_bit - 1'b1;
            if (r_sq_bit == '0)
                r_m <= {1'b0, w_sq_next} + EXP_W'(1);
        end
        if (r_sq_fin)
            r_e <= w_e;
    end

    // ---- slot hash: two partial products, then the upper word mod depth
    assign w_key = i_cmd.giant ? r_g : r_rp;
    assign w_h   = r_hl[2*DATA_W-1:DATA_W] + r_hh;

    always_ff @(posedge i_clk) begin
        if (i_cmd.hash_start) begin
            r_hl <= {{DATA_W{1'b0}}, w_key} * {{DATA_W{1'b0}}, HASH_C_LO};
            r_hh <= w_key * HASH_C_HI;
        end
    end

    // depth not a power of two: reciprocal quotient, remainder, one correction
    assign w_hq_full = {{DATA_W{1'b0}}, w_h} * {{DATA_W{1'b0}}, HASH_RECIP};
    assign w_hr_fix  = (r_hr >= DEPTH_D) ? (r_hr - DEPTH_D) : r_hr;

    always_ff @(posedge i_clk) begin
        if (r_hs1)
            r_hq <= w_hq_full[2*DATA_W-1:DATA_W];
        if (r_hs2)
            r_hr <= w_h - r_hq * DEPTH_D;
    end

    assign w_hash_fin = IS_POW2 ? r_hs1 : r_hs3;
    assign w_hash_idx = IS_POW2 ? w_h[IDX_W-1:0] : w_hr_fix[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hs1   <= 1'b0;
            r_hs2   <= 1'b0;
            r_hs3   <= 1'b0;
            r_hdone <= 1'b0;
        end else begin
            r_hs1   <= i_cmd.hash_start;
            r_hs2   <= r_hs1;
            r_hs3   <= r_hs2;
            r_hdone <= w_hash_fin;
        end
    end

    // ---- slot index, probe count and clear sweep
    always_ff @(posedge i_clk) begin
        if (w_hash_fin) begin
            r_idx   <= w_hash_idx;
            r_probe <= '0;
        end else if (i_cmd.probe_next) begin
            r_idx   <= (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;
            r_probe <= r_probe + 1'b1;
        end
        if (i_cmd.load)
            r_clr_idx <= '0;
        else if (i_cmd.clr_step)
            r_clr_idx <= r_clr_idx + 1'b1;
    end

    // ---- table memory: entry is {valid, key, exponent}
    assign w_we    = i_cmd.clr_step | i_cmd.tab_wr;
    assign w_waddr = i_cmd.clr_step ? r_clr_idx : r_idx;
    assign w_wdata = i_cmd.clr_step ? '0 : {1'b1, r_rp, r_r};

    always_ff @(posedge i_clk) begin
        if (w_we)
            mem[w_waddr] <= w_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd)
            r_rd <= mem[r_idx];
    end

    // ---- modular multiplier and its operand routing
    always_comb begin
        case (i_cmd.mul_op)
            MUL_BABY:  begin w_mx = w_bred; w_my = r_rp;  end
            MUL_SQ:    begin w_mx = r_acc;  w_my = r_acc; end
            MUL_POWB:  begin w_mx = w_bred; w_my = r_acc; end
            MUL_GIANT: begin w_mx = r_acc;  w_my = r_g;   end
            default:   begin w_mx = r_acc;  w_my = r_g;   end
        endcase
    end

    dlb_modmul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_x     (w_mx),
        .i_y     (w_my),
        .i_p     (r_p),
        .o_done  (mm_done),
        .o_prod  (mm_prod)
    );

    // ---- loop registers
    assign w_x = r_qm + {{(QM_W-EXP_W){1'b0}}, r_rd[EXP_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start)
            r_mul_op <= i_cmd.mul_op;

        if (i_cmd.prep) begin
            r_rp <= DATA_W'(1);
            r_r  <= '0;
        end else begin
            if (mm_done && (r_mul_op == MUL_BABY))
                r_rp <= mm_prod;
            if (i_cmd.r_next)
                r_r <= r_r + 1'b1;
        end

        // exponentiation accumulator doubles as the giant factor
        if (i_cmd.pow_init) begin
            r_acc <= DATA_W'(1);
            r_bit <= EBIT_W'(E_W - 1);
        end else begin
            if (mm_done && ((r_mul_op == MUL_SQ) || (r_mul_op == MUL_POWB)))
                r_acc <= mm_prod;
            if (i_cmd.bit_next)
                r_bit <= r_bit - 1'b1;
        end

        if (i_cmd.g_init) begin
            r_g  <= r_target;
            r_q  <= '0;
            r_qm <= '0;
        end else begin
            if (mm_done && (r_mul_op == MUL_GIANT))
                r_g <= mm_prod;
            if (i_cmd.q_next) begin
                r_q  <= r_q + 1'b1;
                r_qm <= r_qm + {{(QM_W-EXP_W){1'b0}}, r_m};
            end
        end
    end

    // ---- result and output registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_hit) begin
            r_res_found <= 1'b1;
            r_res_val   <= w_x[DATA_W-1:0];
        end else if (i_cmd.res_miss) begin
            r_res_found <= 1'b0;
            r_res_val   <= '0;
        end
        if (i_cmd.out_load) begin
            r_out_found <= r_res_found;
            r_out_val   <= r_res_val;
        end
    end

    // ---- status
    always_comb begin
        o_sts.mod_small  = r_p < DATA_W'(2);
        o_sts.clr_last   = r_clr_idx == IDX_LAST;
        o_sts.hash_done  = r_hdone;
        o_sts.ent_valid  = r_rd[ENT_W-1];
        o_sts.key_hit    = r_rd[ENT_W-1] && (r_rd[ENT_W-2 -: DATA_W] == w_key);
        o_sts.probe_last = r_probe == IDX_LAST;
        o_sts.mul_done   = mm_done;
        o_sts.r_last     = r_r == r_m;
        o_sts.bit_set    = r_e[r_bit];
        o_sts.bit_last   = r_bit == '0;
        o_sts.q_last     = r_q == r_m;
        o_sts.x_ok       = w_x < {{(QM_W-DATA_W){1'b0}}, r_p};
    end

    assign o_found     = r_out_found;
    assign o_log_value = r_out_val;

    // base reduction finishes inside the clear sweep; its pulse is not needed
    logic w_unused;
    assign w_unused = brem_done;
endmodule

### src/dlb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlb_ctrl
// Sequencer: clear sweep, baby phase, exponentiation, giant phase, and the
// input/output handshakes.
// ----------------------------------------------------------------------------
module dlb_ctrl import dlb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);
    typedef enum logic [15:0] {
        S_IDLE  = 16'b0000_0000_0000_0001,
        S_CHECK = 16'b0000_0000_0000_0010,
        S_CLR   = 16'b0000_0000_0000_0100,
        S_HASH  = 16'b0000_0000_0000_1000,
        S_HWAIT = 16'b0000_0000_0001_0000,
        S_RD    = 16'b0000_0000_0010_0000,
        S_CHK   = 16'b0000_0000_0100_0000,
        S_BMUL  = 16'b0000_0000_1000_0000,
        S_BWAIT = 16'b0000_0001_0000_0000,
        S_PSQ   = 16'b0000_0010_0000_0000,
        S_PSQW  = 16'b0000_0100_0000_0000,
        S_PMB   = 16'b0000_1000_0000_0000,
        S_PMBW  = 16'b0001_0000_0000_0000,
        S_GMUL  = 16'b0010_0000_0000_0000,
        S_GWAIT = 16'b0100_0000_0000_0000,
        S_FIN   = 16'b1000_0000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_giant, n_giant;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_giant     = r_giant;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.giant = r_giant;
        o_in_ready  = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.mod_small) begin
                    o_cmd.res_miss = 1'b1;
                    n_state        = S_FIN;
                end else begin
                    o_cmd.prep = 1'b1;
                    n_state    = S_CLR;
                end
            end
            // root and base reduction run during the sweep
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_giant = 1'b0;
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash_start = 1'b1;
                n_state          = S_HWAIT;
            end
            S_HWAIT: begin
                if (i_sts.hash_done)
                    n_state = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CHK;
            end
            // probe result: store (baby) or look up (giant)
            S_CHK: begin
                if (!r_giant) begin
                    if (!i_sts.ent_valid || i_sts.key_hit) begin
                        o_cmd.tab_wr = 1'b1;
                        n_state      = S_BMUL;
                    end else if (i_sts.probe_last) begin
                        n_state = S_BMUL;
                    end else begin
                        o_cmd.probe_next = 1'b1;
                        n_state          = S_RD;
                    end
                end else begin
                    if (i_sts.key_hit) begin
                        if (i_sts.x_ok) begin
                            o_cmd.res_hit = 1'b1;
                            n_state       = S_FIN;
                        end else begin
                            n_state = S_GMUL;
                        end
                    end else if (!i_sts.ent_valid || i_sts.probe_last) begin
                        n_state = S_GMUL;
                    end else begin
                        o_cmd.probe_next = 1'b1;
                        n_state          = S_RD;
                    end
                end
            end
            S_BMUL: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_op    = MUL_BABY;
                n_state         = S_BWAIT;
            end
            S_BWAIT: begin
                if (i_sts.mul_done) begin
                    if (i_sts.r_last) begin
                        o_cmd.pow_init = 1'b1;
                        n_state        = S_PSQ;
                    end else begin
                        o_cmd.r_next = 1'b1;
                        n_state      = S_HASH;
                    end
                end
            end
            // square-and-multiply, exponent bits from the top
            S_PSQ: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_op    = MUL_SQ;
                n_state         = S_PSQW;
            end
            S_PSQW: begin
                if (i_sts.mul_done) begin
                    if (i_sts.bit_set) begin
                        n_state = S_PMB;
                    end else if (i_sts.bit_last) begin
                        o_cmd.g_init = 1'b1;
                        n_giant      = 1'b1;
                        n_state      = S_HASH;
                    end else begin
                        o_cmd.bit_next = 1'b1;
                        n_state        = S_PSQ;
                    end
                end
            end
            S_PMB: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_op    = MUL_POWB;
                n_state         = S_PMBW;
            end
            S_PMBW: begin
                if (i_sts.mul_done) begin
                    if (i_sts.bit_last) begin
                        o_cmd.g_init = 1'b1;
                        n_giant      = 1'b1;
                        n_state      = S_HASH;
                    end else begin
                        o_cmd.bit_next = 1'b1;
                        n_state        = S_PSQ;
                    end
                end
            end
            S_GMUL: begin
                if (i_sts.q_last) begin
                    o_cmd.res_miss = 1'b1;
                    n_state        = S_FIN;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = MUL_GIANT;
                    n_state         = S_GWAIT;
                end
            end
            S_GWAIT: begin
                if (i_sts.mul_done) begin
                    o_cmd.q_next = 1'b1;
                    n_state      = S_HASH;
                end
            end
            // hand the result to the output register once it is free
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_giant     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_giant     <= n_giant;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

### src/discrete_log_bsgs.sv
`timescale 1ns / 1ps
// Run time grows with TABLE_DEPTH (table clear) and with m = 1 + isqrt(modulus);
//   a modulus below two goes straight to the result without a table clear.
// Each modular multiply runs on the one shared bit-serial multiplier; every
//   baby and giant step is one multiply plus a hash and table probes on one memory port.
// One item at a time; the next item is taken while a result waits in the output register.
// Reset (synchronous, active low) clears the sequencer and control flags; table per item.
// ----------------------------------------------------------------------------
// discrete_log_bsgs
// Discrete logarithm engine by baby-step giant-step with an on-chip hash table.
// ----------------------------------------------------------------------------
module discrete_log_bsgs import dlb_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = 131072
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dlb_in_if.sink     i_in,
    dlb_out_if.source  o_out
);
    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    dlb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // arithmetic, table and result registers
    dlb_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_base      (i_in.base),
        .i_target    (i_in.target),
        .i_modulus   (i_in.modulus),
        .o_sts       (sts),
        .o_found     (o_out.found),
        .o_log_value (o_out.log_value)
    );
endmodule

### tb/discrete_log_bsgs_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// discrete_log_bsgs_tb
// Drives base/target/modulus items with random gaps and output back-pressure.
// A behavioural baby-step giant-step solver, with its own hash table at the
// same depth, predicts each result; results are checked in order.
// ----------------------------------------------------------------------------
module discrete_log_bsgs_tb import dlb_pkg::*; ();

    // small table keeps the per-item clearing pass short
    localparam int unsigned TDEPTH = 512;

    typedef struct packed {
        logic        found;
        logic [31:0] log_value;
    } t_log_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dlb_in_if  in_if ();
    dlb_out_if out_if ();

    discrete_log_bsgs #(.TABLE_DEPTH(TDEPTH)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    t_log_res    log_expected_q[$];
    int unsigned mismatches = 0;
    longint      cycle_cnt = 0;
    longint      cycle_limit = 200000;

    // predictor hash table
    bit [31:0] hk_key[TDEPTH];
    bit [16:0] hk_exp[TDEPTH];
    bit        hk_vld[TDEPTH];

    initial begin
        in_if.valid   = 1'b0;
        in_if.base    = '0;
        in_if.target  = '0;
        in_if.modulus = '0;
        out_if.ready  = 1'b0;
    end

    // gap length: mostly short, a few long
    function automatic int unsigned gap_len();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
        return $urandom_range(1, 4);
    endfunction

    function automatic longint unsigned mulm(longint unsigned x, longint unsigned y,
                                              longint unsigned p);
        return ((x % p) * (y % p)) % p;
    endfunction

    function automatic longint unsigned powm(longint unsigned x, longint unsigned e,
                                             longint unsigned p);
        longint unsigned acc;
        acc = 1;
        for (int b = 63; b >= 0; b--) begin
            acc = mulm(acc, acc, p);
            if (e[b]) acc = mulm(acc, x, p);
        end
        return acc;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned lo, hi, mid;
        lo = 0;
        hi = 64'hFFFF_FFFF;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic int unsigned slot_of(bit [31:0] key);
        longint unsigned h;
        h = {32'd0, key} * {HASH_C_HI, HASH_C_LO};
        return 32'((h >> 32) % TDEPTH);
    endfunction

    function automatic void table_store(bit [31:0] key, bit [16:0] r);
        int unsigned idx;
        idx = slot_of(key);
        for (int n = 0; n < TDEPTH; n++) begin
            if (!hk_vld[idx]) begin
                hk_vld[idx] = 1'b1;
                hk_key[idx] = key;
                hk_exp[idx] = r;
                return;
            end
            if (hk_key[idx] == key) begin
                hk_exp[idx] = r;
                return;
            end
            idx = (idx + 1 == TDEPTH) ? 0 : idx + 1;
        end
    endfunction

    function automatic bit table_lookup(bit [31:0] key, output bit [16:0] r);
        int unsigned idx;
        idx = slot_of(key);
        r = '0;
        for (int n = 0; n < TDEPTH; n++) begin
            if (!hk_vld[idx]) return 1'b0;
            if (hk_key[idx] == key) begin
                r = hk_exp[idx];
                return 1'b1;
            end
            idx = (idx + 1 == TDEPTH) ? 0 : idx + 1;
        end
        return 1'b0;
    endfunction

    // expected discrete logarithm for one item
    function automatic t_log_res solve_log(bit [31:0] b, bit [31:0] t, bit [31:0] p);
        t_log_res        res;
        longint unsigned m, pw, factor, g, x;
        bit [16:0]       e;
        res = '0;
        foreach (hk_vld[i]) hk_vld[i] = 1'b0;
        if (p < 2) return res;
        m = 1 + isqrt(p);
        pw = 1;
        for (longint unsigned r = 0; r <= m; r++) begin
            table_store(pw[31:0], r[16:0]);
            pw = mulm(b, pw, p);
        end
        factor = powm(b, (p - 2) * m, p);
        g = t;
        for (longint unsigned q = 0; q <= m; q++) begin
            if (table_lookup(g[31:0], e)) begin
                x = q * m + e;
                if (x < p) begin
                    res.found = 1'b1;
                    res.log_value = x[31:0];
                    return res;
                end
            end
            g = mulm(g, factor, p);
        end
        return res;
    endfunction

    function automatic bit is_prime(int unsigned v);
        if (v < 2) return 1'b0;
        for (int unsigned d = 2; d * d <= v; d++)
            if (v % d == 0) return 1'b0;
        return 1'b1;
    endfunction

    function automatic int unsigned rand_prime(int unsigned lo, int unsigned hi);
        int unsigned v;
        v = $urandom_range(lo, hi);
        while (!is_prime(v)) v = (v >= hi) ? lo : v + 1;
        return v;
    endfunction

    // send one item, predicting its result once it is accepted
    task automatic send_item(bit [31:0] b, bit [31:0] t, bit [31:0] p);
        longint unsigned m;
        repeat (gap_len()) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid   = 1'b1;
        in_if.base    = b;
        in_if.target  = t;
        in_if.modulus = p;
        do @(posedge i_clk); while (!in_if.ready);
        log_expected_q.push_back(solve_log(b, t, p));
        m = (p < 2) ? 0 : 1 + isqrt(p);
        // every baby and giant step may probe the whole table
        cycle_limit += 4 * (TDEPTH + 2 * (m + 1) * (50 + 2 * TDEPTH) + 4000) + 1000;
        @(negedge i_clk);
    endtask

    // output back-pressure
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ($urandom_range(0, 49) == 0) begin
                out_if.ready = 1'b0;
                repeat (gap_len()) @(negedge i_clk);
            end
            out_if.ready = ($urandom_range(0, 3) != 0);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_log_res want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (log_expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result found=%0b log=%0d",
                             out_if.found, out_if.log_value);
            end else begin
                want = log_expected_q.pop_front();
                if (out_if.found !== want.found || out_if.log_value !== want.log_value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp found=%0b log=%0d, got %0b %0d",
                                 want.found, want.log_value, out_if.found, out_if.log_value);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > cycle_limit) begin
            $display("discrete_log_bsgs: mismatch");
            $finish;
        end
    end

    // moduli below two give no logarithm; the third item uses modulus two
    task automatic test_small_modulus();
        send_item(32'd5, 32'd0, 32'd0);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
        send_item(32'd1, 32'd1, 32'd2);
    endtask

    // base and target edge values on small primes
    task automatic test_edge_values();
        send_item(32'd0, 32'd0, 32'd7);          // zero base, zero target
        send_item(32'd0, 32'd1, 32'd7);
        send_item(32'd1, 32'd1, 32'd11);
        send_item(32'd1, 32'd5, 32'd11);         // not found
        send_item(32'd12, 32'd1, 32'd13);        // base p-1, repeated powers
        send_item(32'd2, 32'd10, 32'd13);
        send_item(32'd3, 32'd13, 32'd13);        // target equals modulus
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'd101);  // unreduced operands
        send_item(32'd5, 32'd3, 32'd65537);
        send_item(32'd2, 32'd0, 32'd263);        // zero target, never found
    endtask

    // one full-width modulus; base p-1 keeps only two keys in the table
    task automatic test_wide_modulus();
        send_item(32'hFFFF_FFFE, 32'h8000_0001, 32'hFFFF_FFFF);
    endtask

    // random items, mostly targets that are a power of the base
    task automatic test_random();
        int unsigned p, b, t;
        for (int i = 0; i < 100; i++) begin
            p = ($urandom_range(0, 9) == 0) ? rand_prime(2000, 250000)
                                              : rand_prime(2, 2000);
            b = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, p - 1);
            case ($urandom_range(0, 5))
                0: t = $urandom();
                1: t = $urandom_range(0, p - 1);
                default: t = 32'(powm(b, $urandom_range(0, p - 1), p));
            endcase
            send_item(b, t, p);
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_small_modulus();
        test_edge_values();
        test_wide_modulus();
        test_random();
        in_if.valid = 1'b0;
        while (log_expected_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0)
            $display("discrete_log_bsgs: match");
        else
            $display("discrete_log_bsgs: mismatch");
        $finish;
    end

endmodule

### discrete_log_bsgs.f
src/dlb_pkg.sv
src/dlb_in_if.sv
src/dlb_out_if.sv
src/dlb_rem.sv
src/dlb_modmul.sv
src/dlb_datapath.sv
src/dlb_ctrl.sv
src/discrete_log_bsgs.sv
tb/discrete_log_bsgs_tb.sv
